// ===== src/lbts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbts_pkg
// Shared widths, register indexes, reset values and control structs of the
// lane blob tracker.
// ----------------------------------------------------------------------------
package lbts_pkg;

	localparam int IMAGE_WIDTH  = 640;
	localparam int IMAGE_HEIGHT = 128;

	// field widths
	localparam int XW    = 10;   // x coordinates, box left, box width
	localparam int YW    = 8;    // tracked y and box height
	localparam int TOPW  = 7;    // box top
	localparam int DW    = 8;    // distance values that can ever be taken
	localparam int RADW  = 21;   // squared distance
	localparam int ERRW  = 11;
	localparam int DRVW  = 12;
	localparam int GAINW = 16;
	localparam int CIDXW = 3;
	localparam int CDATW = 16;

	// configuration register indexes
	localparam logic [CIDXW-1:0] CFG_DIST_LIMIT  = 3'd0;
	localparam logic [CIDXW-1:0] CFG_BOTTOM      = 3'd1;
	localparam logic [CIDXW-1:0] CFG_OFFSET      = 3'd2;
	localparam logic [CIDXW-1:0] CFG_BASE_SPEED  = 3'd3;
	localparam logic [CIDXW-1:0] CFG_GAIN        = 3'd4;

	// register reset values
	localparam logic [7:0]       DIST_LIMIT_RST = 8'd120;
	localparam logic [7:0]       BOTTOM_RST     = 8'd60;
	localparam logic [XW-1:0]    OFFSET_RST     = 10'd320;
	localparam logic [XW-1:0]    BASE_RST       = 10'd100;
	localparam logic [GAINW-1:0] GAIN_RST       = 16'd20972;

	// tracked center reset values
	localparam logic [XW-1:0] LEFT_X_RST  = XW'(IMAGE_WIDTH / 4);
	localparam logic [XW-1:0] RIGHT_X_RST = XW'(3 * IMAGE_WIDTH / 4);
	localparam logic [YW-1:0] CENTER_Y_RST = 8'd45;

	// controller to datapath
	typedef struct packed {
		logic ready;       // input channel ready
		logic sum;         // add squares, load root units
		logic root_step;   // two root bits per side
		logic update;      // compare and move tracked centers
		logic mult;        // lane error times gain
		logic emit;        // load output register, clear bests
	} lbts_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_valid;
		logic in_box;
		logic in_last;
		logic last_q;
		logic out_free;
	} lbts_status_t;

endpackage

// ===== src/lbts_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbts_box_if / lbts_steer_if
// Valid/ready channels for blob boxes in and steering results out.
// ----------------------------------------------------------------------------
interface lbts_box_if;
	import lbts_pkg::*;

	logic            valid;
	logic            ready;
	logic            box_valid;
	logic [XW-1:0]   box_left;
	logic [TOPW-1:0] box_top;
	logic [XW-1:0]   box_width;
	logic [YW-1:0]   box_height;
	logic            last_box;

	modport source (output valid, box_valid, box_left, box_top, box_width, box_height,
		last_box, input ready);
	modport sink (input valid, box_valid, box_left, box_top, box_width, box_height,
		last_box, output ready);
endinterface

interface lbts_steer_if;
	import lbts_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [XW-1:0]          left_center_x;
	logic [XW-1:0]          right_center_x;
	logic signed [ERRW-1:0] lane_error;
	logic signed [DRVW-1:0] left_drive;
	logic signed [DRVW-1:0] right_drive;

	modport source (output valid, left_center_x, right_center_x, lane_error, left_drive,
		right_drive, input ready);
	modport sink (input valid, left_center_x, right_center_x, lane_error, left_drive,
		right_drive, output ready);
endinterface

// ===== src/lbts_root.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbts_root
// Iterative floor square root, two result bits per step, 8-bit result.
// Radicands of 2^16 and above only raise the far flag.
// ----------------------------------------------------------------------------
module lbts_root
	import lbts_pkg::*;
(
	input  logic            clk,
	input  logic            load,
	input  logic            step,
	input  logic [RADW-1:0] rad,
	output logic [DW-1:0]   root,
	output logic            far
);

	logic [15:0]   v_q;
	logic [11:0]   rem_q;
	logic [DW-1:0] root_q;
	logic          far_q;

	logic [11:0]   rem_n;
	logic [DW-1:0] root_n;
	logic [15:0]   v_n;
	logic [11:0]   trial;

	// two restoring digit steps
	always_comb begin
		rem_n  = rem_q;
		root_n = root_q;
		v_n    = v_q;
		trial  = '0;
		for (int i = 0; i < 2; i++) begin
			rem_n = {rem_n[9:0], v_n[15:14]};
			v_n   = {v_n[13:0], 2'b00};
			trial = {2'b00, root_n, 2'b01};
			if (rem_n >= trial) begin
				rem_n  = rem_n - trial;
				root_n = {root_n[DW-2:0], 1'b1};
			end else begin
				root_n = {root_n[DW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q  <= '0;
			root_q <= '0;
			v_q    <= rad[15:0];
			far_q  <= |rad[RADW-1:16];
		end else if (step) begin
			rem_q  <= rem_n;
			root_q <= root_n;
			v_q    <= v_n;
		end
	end

	assign root = root_q;
	assign far  = far_q;

endmodule

// ===== src/lbts_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbts_datapath
// Box center rounding, squared distances, tracked centers, config registers
// and steering arithmetic with the output register.
// ----------------------------------------------------------------------------
module lbts_datapath
	import lbts_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  lbts_cmd_t          cmd,
	output lbts_status_t       status,
	input  logic               cfg_we,
	input  logic [CIDXW-1:0]   cfg_index,
	input  logic [CDATW-1:0]   cfg_wdata,
	lbts_box_if.sink           box_in,
	lbts_steer_if.source       steer_out
);

	// configuration
	logic [7:0]       dist_limit_q;
	logic [7:0]       bottom_q;
	logic [XW-1:0]    offset_q;
	logic [XW-1:0]    base_q;
	logic [GAINW-1:0] gain_q;

	// tracking state
	logic [XW-1:0] left_x_q, right_x_q;
	logic [YW-1:0] left_y_q, right_y_q;
	logic [DW-1:0] left_best_q, right_best_q;
	logic          left_found_q, right_found_q;

	// current box
	logic [XW-1:0] bx_q;
	logic [YW-1:0] by_q;
	logic          low_q;
	logic          last_q;
	logic [19:0]   lsqx_q, rsqx_q;
	logic [15:0]   lsqy_q, rsqy_q;

	// steering
	logic signed [ERRW-1:0] err_q;
	logic signed [27:0]     prod_q;
	logic                   out_valid_q;

	logic [11:0]   sx;
	logic [10:0]   fx, rx;
	logic [8:0]    sy;
	logic [7:0]    fy;
	logic [8:0]    ry;
	logic [XW-1:0] bx;
	logic [YW-1:0] by;
	logic [XW-1:0] ldx, rdx;
	logic [YW-1:0] ldy, rdy;
	logic          in_fire;

	logic [DW-1:0] lroot, rroot;
	logic          lfar, rfar;
	logic          ltake, rtake;

	logic [XW-1:0]          mid;
	logic signed [ERRW:0]   err_w;
	logic signed [ERRW-1:0] err;
	logic signed [28:0]     base_sh, lsum, rsum;
	logic signed [12:0]     ltz, rtz;

	assign in_fire = box_in.valid & cmd.ready;
	assign box_in.ready = cmd.ready;

	// box center, rounded half to even, saturated
	always_comb begin
		sx = {1'b0, box_in.box_left, 1'b0} + {2'b00, box_in.box_width};
		fx = sx[11:1];
		rx = fx + 11'(sx[0] & fx[0]);
		bx = (rx > 11'd1023) ? 10'd1023 : rx[XW-1:0];
		sy = {1'b0, box_in.box_top, 1'b0} + {1'b0, box_in.box_height};
		fy = sy[8:1];
		ry = {1'b0, fy} + 9'(sy[0] & fy[0]);
		by = ry[8] ? 8'd255 : ry[YW-1:0];
		ldx = (bx > left_x_q) ? bx - left_x_q : left_x_q - bx;
		rdx = (bx > right_x_q) ? bx - right_x_q : right_x_q - bx;
		ldy = (by > left_y_q) ? by - left_y_q : left_y_q - by;
		rdy = (by > right_y_q) ? by - right_y_q : right_y_q - by;
	end

	// capture box and squared offsets at the input transfer
	always_ff @(posedge clk) begin
		if (in_fire) begin
			bx_q   <= bx;
			by_q   <= by;
			low_q  <= ({2'b00, box_in.box_top} + {1'b0, box_in.box_height}) > {1'b0, bottom_q};
			last_q <= box_in.last_box;
			lsqx_q <= {10'd0, ldx} * {10'd0, ldx};
			rsqx_q <= {10'd0, rdx} * {10'd0, rdx};
			lsqy_q <= {8'd0, ldy} * {8'd0, ldy};
			rsqy_q <= {8'd0, rdy} * {8'd0, rdy};
		end
	end

	lbts_root u_root_l (
		.clk  (clk),
		.load (cmd.sum),
		.step (cmd.root_step),
		.rad  ({1'b0, lsqx_q} + {5'd0, lsqy_q}),
		.root (lroot),
		.far  (lfar)
	);

	lbts_root u_root_r (
		.clk  (clk),
		.load (cmd.sum),
		.step (cmd.root_step),
		.rad  ({1'b0, rsqx_q} + {5'd0, rsqy_q}),
		.root (rroot),
		.far  (rfar)
	);

	// acceptance per side
	assign ltake = !lfar && (!left_found_q || lroot < left_best_q) && low_q
		&& lroot < dist_limit_q;
	assign rtake = !rfar && (!right_found_q || rroot < right_best_q) && low_q
		&& rroot < dist_limit_q;

	// tracking state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_limit_q  <= DIST_LIMIT_RST;
			bottom_q      <= BOTTOM_RST;
			offset_q      <= OFFSET_RST;
			base_q        <= BASE_RST;
			gain_q        <= GAIN_RST;
			left_x_q      <= LEFT_X_RST;
			right_x_q     <= RIGHT_X_RST;
			left_y_q      <= CENTER_Y_RST;
			right_y_q     <= CENTER_Y_RST;
			left_best_q   <= '0;
			right_best_q  <= '0;
			left_found_q  <= 1'b0;
			right_found_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_DIST_LIMIT: dist_limit_q <= cfg_wdata[7:0];
					CFG_BOTTOM:     bottom_q     <= cfg_wdata[7:0];
					CFG_OFFSET:     offset_q     <= cfg_wdata[XW-1:0];
					CFG_BASE_SPEED: base_q       <= cfg_wdata[XW-1:0];
					CFG_GAIN:       gain_q       <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.update) begin
				if (ltake) begin
					left_x_q     <= bx_q;
					left_y_q     <= by_q;
					left_best_q  <= lroot;
					left_found_q <= 1'b1;
				end
				if (rtake) begin
					right_x_q     <= bx_q;
					right_y_q     <= by_q;
					right_best_q  <= rroot;
					right_found_q <= 1'b1;
				end
			end
			if (cmd.emit) begin
				left_best_q   <= '0;
				right_best_q  <= '0;
				left_found_q  <= 1'b0;
				right_found_q <= 1'b0;
			end
		end
	end

	// lane error and scaled error
	always_comb begin
		mid   = 10'(({1'b0, left_x_q} + {1'b0, right_x_q}) >> 1);
		err_w = $signed({2'b00, mid}) - $signed({2'b00, offset_q});
		err   = err_w[ERRW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.mult) begin
			err_q  <= err;
			prod_q <= 28'(err) * 28'($signed({1'b0, gain_q}));
		end
	end

	// drives: add base on the left, subtract it on the right, truncate toward zero, saturate
	always_comb begin
		base_sh = $signed({3'b000, base_q, 16'd0});
		lsum    = 29'(prod_q) + base_sh;
		rsum    = 29'(prod_q) - base_sh;
		ltz     = lsum[28] ? 13'((lsum + 29'sd65535) >>> 16) : 13'(lsum >>> 16);
		rtz     = rsum[28] ? 13'((rsum + 29'sd65535) >>> 16) : 13'(rsum >>> 16);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (steer_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			steer_out.left_center_x  <= left_x_q;
			steer_out.right_center_x <= right_x_q;
			steer_out.lane_error     <= err_q;
			steer_out.left_drive     <= (ltz > 13'sd2047) ? 12'sd2047 :
				(ltz < -13'sd2048) ? -12'sd2048 : ltz[DRVW-1:0];
			steer_out.right_drive    <= (rtz > 13'sd2047) ? 12'sd2047 :
				(rtz < -13'sd2048) ? -12'sd2048 : rtz[DRVW-1:0];
		end
	end

	assign steer_out.valid = out_valid_q;

	assign status.in_valid = box_in.valid;
	assign status.in_box   = box_in.box_valid;
	assign status.in_last  = box_in.last_box;
	assign status.last_q   = last_q;
	assign status.out_free = !out_valid_q || steer_out.ready;

	// tracked centers only move on an update
	a_center_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.update |=> $stable(left_x_q) && $stable(right_x_q))
		else $error("tracked center moved outside update");

	// a result clears both bests
	a_best_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> !left_found_q && !right_found_q)
		else $error("bests not cleared at frame end");

	// a waiting result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		steer_out.valid && !steer_out.ready |=> steer_out.valid
		&& $stable(steer_out.lane_error) && $stable(steer_out.left_drive)
		&& $stable(steer_out.right_drive))
		else $error("result changed while waiting");

endmodule

// ===== src/lbts_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbts_ctrl
// Sequencer: box capture, radicand sum, four root steps, update, then the
// steering multiply and result at frame end.
// ----------------------------------------------------------------------------
module lbts_ctrl
	import lbts_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  lbts_status_t status,
	output lbts_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SUM,
		S_ROOT,
		S_UPD,
		S_MUL,
		S_FIN
	} state_t;

	state_t     state_q;
	logic [1:0] step_q;

	// state and root step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (status.in_valid) begin
						if (status.in_box)
							state_q <= S_SUM;
						else if (status.in_last)
							state_q <= S_MUL;
					end
				end
				S_SUM: begin
					state_q <= S_ROOT;
					step_q  <= '0;
				end
				S_ROOT: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3)
						state_q <= S_UPD;
				end
				S_UPD: begin
					state_q <= status.last_q ? S_MUL : S_IDLE;
				end
				S_MUL: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (status.out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// commands
	always_comb begin
		cmd           = '0;
		cmd.ready     = (state_q == S_IDLE);
		cmd.sum       = (state_q == S_SUM);
		cmd.root_step = (state_q == S_ROOT);
		cmd.update    = (state_q == S_UPD);
		cmd.mult      = (state_q == S_MUL);
		cmd.emit      = (state_q == S_FIN) && status.out_free;
	end

	// the root runs exactly four steps
	a_root_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SUM |=> ##4 state_q == S_UPD)
		else $error("root step count wrong");

	// a box that ends no frame returns straight to idle
	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD && !status.last_q) |=> state_q == S_IDLE)
		else $error("result sequence without frame end");

	// an empty frame end goes straight to the multiply
	a_empty_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ready && status.in_valid && !status.in_box && status.in_last)
		|=> state_q == S_MUL)
		else $error("empty frame end not handled");

endmodule

// ===== src/lane_blob_tracker_steer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lane_blob_tracker_steer
// Tracks left and right lane centers from blob boxes and emits lane error
// and drive values at each frame end.
// ----------------------------------------------------------------------------
// Sequence: a box item runs capture, sum, 4 root steps and update; a
//   frame-end item adds multiply and result load, an empty frame end runs
//   capture, multiply and load; the load waits for a free output register.
// Throughput: one item at a time, set by the 2-bit-per-cycle square root.
// Reset: arst_n clears config to defaults, centers to (160,45)/(480,45),
//   bests to none found, and empties the output register.
module lane_blob_tracker_steer
	import lbts_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CIDXW-1:0] cfg_index,
	input  logic [CDATW-1:0] cfg_wdata,
	lbts_box_if.sink         box_in,
	lbts_steer_if.source     steer_out
);

	lbts_cmd_t    cmd;
	lbts_status_t status;

	lbts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	lbts_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.box_in    (box_in),
		.steer_out (steer_out)
	);

endmodule
